// ===== rtl/core/signed_decimal_radix_sorter_top_assert.svh =====
// assertion macros for the signed decimal radix sorter
// expects clk and arst_n in the scope of each use
`ifndef SIGNED_DECIMAL_RADIX_SORTER_TOP_ASSERT_SVH
`define SIGNED_DECIMAL_RADIX_SORTER_TOP_ASSERT_SVH

// same-cycle implication
`define SDRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sdrs_pkg.sv =====
// types and constants shared by the signed decimal radix sorter
// no dependencies
package sdrs_pkg;

	localparam int unsigned RADIX = 10;
	localparam logic [3:0] PFX_END = 4'(RADIX);
	localparam logic [31:0] KEY_FLIP = 32'h8000_0000;
	// floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
	localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_beat_t;

	// stored element: order key, remaining quotient, current digit
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] quot;
		logic [3:0]  digit;
	} ent_t;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_CHECK   = 6'b000010,
		ST_COUNT   = 6'b000100,
		ST_PREFIX  = 6'b001000,
		ST_SCATTER = 6'b010000,
		ST_EMIT    = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic start_pass;
		logic count;
		logic prefix;
		logic scatter;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic scat_done;
		logic pfx_done;
		logic more;
	} stat_t;

endpackage

// ===== rtl/core/signed_decimal_radix_sorter_top.sv =====
// Loading accepts one item per cycle; busy stays low until an item marked last.
// Sorting runs one decimal pass per digit of the largest offset key, up to ten,
// each a check, a count walk, a running bucket sum and a scatter walk.
// Output follows the final check: n results on back-to-back cycles, one strobe each;
// the receiver cannot stall, so no beat ever waits.
// Asynchronous active-low reset empties the run and clears the buckets.
module signed_decimal_radix_sorter_top import sdrs_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_beat_t  item,
	output out_beat_t result,
	output logic      strobe
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	sdrs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_in (item.last_in),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	// storage and pass walks
	sdrs_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.strobe (strobe)
	);

endmodule

// ===== rtl/core/sdrs_ctrl.sv =====
// controller state machine of the signed decimal radix sorter
// depends on sdrs_pkg
module sdrs_ctrl import sdrs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  last_in,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && last_in) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = stat.more ? ST_COUNT : ST_EMIT;
			end
			ST_COUNT: begin
				if (stat.walk_done) state_d = ST_PREFIX;
			end
			ST_PREFIX: begin
				if (stat.pfx_done) state_d = ST_SCATTER;
			end
			ST_SCATTER: begin
				if (stat.scat_done) state_d = ST_CHECK;
			end
			ST_EMIT: begin
				if (stat.walk_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// commands to the datapath
	always_comb begin
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.start_pass = (state_q == ST_CHECK);
		cmd.count      = (state_q == ST_COUNT);
		cmd.prefix     = (state_q == ST_PREFIX);
		cmd.scatter    = (state_q == ST_SCATTER);
		cmd.emit       = (state_q == ST_EMIT);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/core/sdrs_datapath.sv =====
// datapath: run storage, digit buckets and pass walks of the radix sorter
// depends on sdrs_pkg and signed_decimal_radix_sorter_top_assert.svh
`include "signed_decimal_radix_sorter_top_assert.svh"
module sdrs_datapath import sdrs_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  item,
	input  cmd_t      cmd,
	output stat_t     stat,
	output out_beat_t result,
	output logic      strobe
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	ent_t mem0 [MAX_ITEMS];
	ent_t mem1 [MAX_ITEMS];
	ent_t rd0_q, rd1_q, rdata;
	logic sel_q;

	logic [CW-1:0] cnt_q, idx_q;
	logic dropped_q, anynz_q;
	logic [CW-1:0] bkt_q [RADIX];
	logic [3:0] pfx_q;

	logic v_s1;
	logic [CW-1:0] a_s1;
	logic v_s2;
	logic [AW-1:0] a_s2;
	logic [63:0] prod_s2;
	ent_t e_s2;

	logic rd_go, load_we, src_we, dst_we;
	logic [AW-1:0] raddr, src_addr, dst_addr;
	logic [CW-1:0] rd_idx, pos;
	ent_t src_data;
	logic [31:0] key_in, qn, rem;
	logic [3:0] dg;

	assign rdata  = sel_q ? rd1_q : rd0_q;
	assign key_in = item.value ^ KEY_FLIP;

	// read side of the walks
	always_comb begin
		rd_idx = cmd.scatter ? CW'(idx_q - 1'b1) : idx_q;
		raddr  = rd_idx[AW-1:0];
		rd_go  = ((cmd.count || cmd.emit) && (idx_q != cnt_q)) ||
			(cmd.scatter && (idx_q != '0));
	end

	// digit and next quotient of the count stage
	always_comb begin
		qn  = {3'b000, prod_s2[63:RECIP_SHIFT]};
		rem = e_s2.quot - (qn << 3) - (qn << 1);
		dg  = rem[3:0];
	end

	// write side: load and count write back to source, scatter to destination
	always_comb begin
		load_we = cmd.load && (cnt_q != MAX_CNT);
		src_we  = load_we || v_s2;
		if (v_s2) begin
			src_addr = a_s2;
			src_data = '{key: e_s2.key, quot: qn, digit: dg};
		end else begin
			src_addr = cnt_q[AW-1:0];
			src_data = '{key: key_in, quot: key_in, digit: 4'd0};
		end
		pos      = CW'(bkt_q[rdata.digit] - 1'b1);
		dst_addr = pos[AW-1:0];
		dst_we   = cmd.scatter && v_s1;
	end

	// ping-pong memories
	always_ff @(posedge clk) begin
		rd0_q <= mem0[raddr];
		rd1_q <= mem1[raddr];
		if (sel_q ? dst_we : src_we) mem0[sel_q ? dst_addr : src_addr] <=
			sel_q ? rdata : src_data;
		if (sel_q ? src_we : dst_we) mem1[sel_q ? src_addr : dst_addr] <=
			sel_q ? src_data : rdata;
	end

	// count stage payload
	always_ff @(posedge clk) begin
		prod_s2 <= 64'(rdata.quot) * 64'(RECIP);
		e_s2    <= rdata;
		a_s2    <= a_s1[AW-1:0];
		a_s1    <= rd_idx;
	end

	// control registers, buckets and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			dropped_q <= 1'b0;
			anynz_q   <= 1'b0;
			pfx_q     <= 4'd1;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			for (int i = 0; i < RADIX; i++) bkt_q[i] <= '0;
		end else begin
			v_s1 <= rd_go;
			v_s2 <= v_s1 && cmd.count;
			// run loading
			if (cmd.load) begin
				if (load_we) begin
					cnt_q   <= CW'(cnt_q + 1'b1);
					anynz_q <= anynz_q || (key_in != '0);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			// pass setup
			if (cmd.start_pass) begin
				idx_q   <= '0;
				pfx_q   <= 4'd1;
				anynz_q <= 1'b0;
				for (int i = 0; i < RADIX; i++) bkt_q[i] <= '0;
			end
			if (rd_go) idx_q <= cmd.scatter ? CW'(idx_q - 1'b1) : CW'(idx_q + 1'b1);
			// digit histogram
			if (v_s2) begin
				bkt_q[dg] <= CW'(bkt_q[dg] + 1'b1);
				anynz_q   <= anynz_q || (qn != '0);
			end
			// running sum of buckets
			if (cmd.prefix) begin
				idx_q <= cnt_q;
				if (pfx_q != PFX_END) begin
					bkt_q[pfx_q] <= CW'(bkt_q[pfx_q] + bkt_q[pfx_q - 4'd1]);
					pfx_q        <= pfx_q + 4'd1;
				end
			end
			// stable scatter, last element first
			if (dst_we) bkt_q[rdata.digit] <= pos;
			if (cmd.scatter && stat.scat_done) sel_q <= ~sel_q;
			// end of run
			if (cmd.emit && stat.walk_done) begin
				cnt_q     <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.walk_done = (idx_q == cnt_q) && !v_s1 && !v_s2;
		stat.scat_done = (idx_q == '0) && !v_s1;
		stat.pfx_done  = (pfx_q == PFX_END);
		stat.more      = anynz_q;
	end

	// result beat
	always_comb begin
		strobe              = v_s1 && cmd.emit;
		result.sorted_value = signed'(rdata.key ^ KEY_FLIP);
		result.last_out     = (a_s1 == CW'(cnt_q - 1'b1));
		result.overflow     = dropped_q;
	end

	`SDRS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= MAX_CNT, "item count beyond capacity")
	`SDRS_ASSERT_IMP(a_digit_range, v_s2, dg < PFX_END, "decimal digit out of range")
	`SDRS_ASSERT_NXT(a_last_ends, strobe && result.last_out, !strobe, "beat after last")

endmodule
